// ----- sv/rza_pkg.sv -----
// rza_pkg: shared widths, register indexes and payload types for the RGB zone averager.
// No dependencies; every other file of the block imports it.
`timescale 1ns / 1ps

package rza_pkg;

  localparam int MAX_LINE_PIXELS = 4096;
  localparam int MAX_ZONES       = 64;
  localparam int RESET_ZONES     = 16;

  localparam int PIX_W      = 8;
  localparam int LEN_W      = 13;
  localparam int ZCNT_W     = 7;
  localparam int ZIDX_W     = 6;
  localparam int SUM_W      = 20;
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 13;
  localparam int DSTEP_W    = $clog2(LEN_W + 1);
  localparam int QSTEP_W    = $clog2(PIX_W);

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  localparam logic [CFG_IDX_W-1:0] CFG_LINE_LENGTH = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_ZONE_COUNT  = CFG_IDX_W'(1);

  localparam logic [LEN_W-1:0]  LEN_RESET   = LEN_W'(MAX_LINE_PIXELS);
  localparam logic [ZCNT_W-1:0] ZCNT_RESET  = ZCNT_W'(RESET_ZONES);
  localparam logic [LEN_W-1:0]  ZSIZE_RESET = LEN_W'(MAX_LINE_PIXELS / RESET_ZONES);
  localparam logic [LEN_W-1:0]  LEN_MAX     = LEN_W'(MAX_LINE_PIXELS);
  localparam logic [ZCNT_W-1:0] ZCNT_MAX    = ZCNT_W'(MAX_ZONES);

  typedef struct packed {
    logic [PIX_W-1:0] red;
    logic [PIX_W-1:0] green;
    logic [PIX_W-1:0] blue;
  } pix_t;

  typedef struct packed {
    logic [ZIDX_W-1:0] zone_index;
    logic [PIX_W-1:0]  avg_red;
    logic [PIX_W-1:0]  avg_green;
    logic [PIX_W-1:0]  avg_blue;
    logic              last_zone;
  } res_t;

  // One closed zone handed from the front to the back; cnt of zero is an empty zone.
  typedef struct packed {
    logic [ZIDX_W-1:0] zone;
    logic [SUM_W-1:0]  red_sum;
    logic [SUM_W-1:0]  green_sum;
    logic [SUM_W-1:0]  blue_sum;
    logic [LEN_W-1:0]  cnt;
    logic              last;
  } job_t;

endpackage

// ----- sv/rza_front.sv -----
// rza_front: configuration registers, zone size divider, pixel accumulation and zone close.
// Depends on rza_pkg; pushes closed zones into rza_queue.
`timescale 1ns / 1ps

module rza_front (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  rza_pkg::pix_t                  in_data_i,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [rza_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [rza_pkg::CFG_DATA_W-1:0] cfg_data_i,
  output logic                           q_push_o,
  output rza_pkg::job_t                  q_job_o,
  input  logic                           q_full_i
);
  import rza_pkg::*;

  logic [LEN_W-1:0]   len_q;
  logic [ZCNT_W-1:0]  zcnt_q;
  logic [LEN_W-1:0]   zsize_q;
  logic               dbusy_q;
  logic [DSTEP_W-1:0] dstep_q;
  logic [LEN_W-1:0]   ddvd_q;
  logic [ZCNT_W-1:0]  drem_q;

  logic [SUM_W-1:0]  rsum_q, gsum_q, bsum_q;
  logic [LEN_W-1:0]  pos_q;
  logic [LEN_W-1:0]  pic_q;
  logic [ZIDX_W-1:0] zone_q;
  logic              emp_q;

  logic [LEN_W-1:0]  len_e;
  logic [ZCNT_W-1:0] zones_e;
  logic [ZIDX_W-1:0] last_idx;
  logic [ZCNT_W:0]   rem_sh;
  logic              dge;
  logic [ZCNT_W-1:0] drem_nx;
  logic [LEN_W-1:0]  ddvd_nx;

  logic              cfg_hit;
  logic              start_empty;
  logic              emp_zone;
  logic              emp_end;
  logic              emp_fire;
  logic              pix_acc;
  logic              in_last;
  logic              closes;
  logic [SUM_W-1:0]  rsum_nx, gsum_nx, bsum_nx;
  logic [LEN_W-1:0]  pos_nx, pic_nx;

  always_comb begin
    if (len_q == '0) begin
      len_e = LEN_W'(1);
    end else if (len_q > LEN_MAX) begin
      len_e = LEN_MAX;
    end else begin
      len_e = len_q;
    end
    if (zcnt_q == '0) begin
      zones_e = ZCNT_W'(1);
    end else if (zcnt_q > ZCNT_MAX) begin
      zones_e = ZCNT_MAX;
    end else begin
      zones_e = zcnt_q;
    end
  end

  assign last_idx = ZIDX_W'(zones_e - ZCNT_W'(1));

  // restoring divider, one quotient bit per cycle: zsize = len_e / zones_e
  assign rem_sh  = {drem_q, ddvd_q[LEN_W-1]};
  assign dge     = rem_sh >= {1'b0, zones_e};
  assign drem_nx = dge ? ZCNT_W'(rem_sh - {1'b0, zones_e}) : ZCNT_W'(rem_sh);
  assign ddvd_nx = {ddvd_q[LEN_W-2:0], dge};

  assign cfg_ready_o = 1'b1;
  assign cfg_hit     = cfg_valid_i
                       && (cfg_index_i == CFG_LINE_LENGTH || cfg_index_i == CFG_ZONE_COUNT);

  // zero zone size: the first pixel of a line is taken, then the empty zones go out,
  // then that pixel's own zone closes if the line is one pixel long
  assign start_empty = (pos_q == '0) && (zsize_q == '0);
  assign emp_zone    = zone_q < last_idx;
  assign emp_end     = pos_q >= len_e;
  assign emp_fire    = emp_q && !q_full_i;
  assign in_ready_o  = !dbusy_q && !emp_q && !q_full_i;
  assign pix_acc     = in_valid_i && in_ready_o;

  assign rsum_nx = rsum_q + SUM_W'(in_data_i.red);
  assign gsum_nx = gsum_q + SUM_W'(in_data_i.green);
  assign bsum_nx = bsum_q + SUM_W'(in_data_i.blue);
  assign pos_nx  = pos_q + LEN_W'(1);
  assign pic_nx  = pic_q + LEN_W'(1);
  assign in_last = zone_q >= last_idx;
  assign closes  = in_last ? (pos_nx >= len_e) : (pic_nx >= zsize_q);

  assign q_push_o = (emp_fire && (emp_zone || emp_end)) || (pix_acc && !start_empty && closes);

  always_comb begin
    if (emp_q && emp_zone) begin
      q_job_o = '{zone: zone_q, red_sum: '0, green_sum: '0, blue_sum: '0,
                  cnt: '0, last: 1'b0};
    end else if (emp_q) begin
      q_job_o = '{zone: zone_q, red_sum: rsum_q, green_sum: gsum_q, blue_sum: bsum_q,
                  cnt: pic_q, last: 1'b1};
    end else begin
      q_job_o = '{zone: zone_q, red_sum: rsum_nx, green_sum: gsum_nx, blue_sum: bsum_nx,
                  cnt: pic_nx, last: in_last};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q   <= LEN_RESET;
      zcnt_q  <= ZCNT_RESET;
      zsize_q <= ZSIZE_RESET;
      dbusy_q <= 1'b0;
      dstep_q <= '0;
      ddvd_q  <= '0;
      drem_q  <= '0;
    end else begin
      if (cfg_hit) begin
        if (cfg_index_i == CFG_LINE_LENGTH) begin
          len_q <= cfg_data_i;
        end else begin
          zcnt_q <= cfg_data_i[ZCNT_W-1:0];
        end
        dbusy_q <= 1'b1;
        dstep_q <= '0;
      end else if (dbusy_q) begin
        if (dstep_q == '0) begin
          ddvd_q  <= len_e;
          drem_q  <= '0;
          dstep_q <= DSTEP_W'(LEN_W);
        end else begin
          ddvd_q  <= ddvd_nx;
          drem_q  <= drem_nx;
          dstep_q <= dstep_q - DSTEP_W'(1);
          if (dstep_q == DSTEP_W'(1)) begin
            zsize_q <= ddvd_nx;
            dbusy_q <= 1'b0;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsum_q <= '0;
      gsum_q <= '0;
      bsum_q <= '0;
      pos_q  <= '0;
      pic_q  <= '0;
      zone_q <= '0;
      emp_q  <= 1'b0;
    end else begin
      priority if (cfg_hit) begin
        rsum_q <= '0;
        gsum_q <= '0;
        bsum_q <= '0;
        pos_q  <= '0;
        pic_q  <= '0;
        zone_q <= '0;
        emp_q  <= 1'b0;
      end else if (emp_fire) begin
        if (emp_zone) begin
          zone_q <= zone_q + ZIDX_W'(1);
        end else begin
          emp_q <= 1'b0;
          if (emp_end) begin
            rsum_q <= '0;
            gsum_q <= '0;
            bsum_q <= '0;
            pic_q  <= '0;
            pos_q  <= '0;
            zone_q <= '0;
          end
        end
      end else begin
        if (pix_acc) begin
          if (start_empty) begin
            rsum_q <= rsum_nx;
            gsum_q <= gsum_nx;
            bsum_q <= bsum_nx;
            pos_q  <= pos_nx;
            pic_q  <= pic_nx;
            emp_q  <= 1'b1;
          end else if (closes) begin
            rsum_q <= '0;
            gsum_q <= '0;
            bsum_q <= '0;
            pic_q  <= '0;
            if (in_last) begin
              pos_q  <= '0;
              zone_q <= '0;
            end else begin
              pos_q  <= pos_nx;
              zone_q <= zone_q + ZIDX_W'(1);
            end
          end else begin
            rsum_q <= rsum_nx;
            gsum_q <= gsum_nx;
            bsum_q <= bsum_nx;
            pos_q  <= pos_nx;
            pic_q  <= pic_nx;
          end
        end
      end
    end
  end

  a_pic_below_zsize: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!dbusy_q && zsize_q != '0 && zone_q < last_idx) |-> (pic_q < zsize_q))
    else $error("zone pixel count passed zone size without closing");

  a_line_wraps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (q_push_o && q_job_o.last && !cfg_hit) |=> (pos_q == '0 && zone_q == '0))
    else $error("line did not restart after its last zone");

endmodule

// ----- sv/rza_queue.sv -----
// rza_queue: short queue of closed zones between the front and the back.
// Depends on rza_pkg for job_t and the depth.
`timescale 1ns / 1ps

module rza_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  rza_pkg::job_t job_i,
  output logic          full_o,
  input  logic          pop_i,
  output rza_pkg::job_t job_o,
  output logic          empty_o
);
  import rza_pkg::*;

  job_t              mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_q, rd_q;
  logic [QPTR_W:0]   cnt_q;

  assign full_o  = cnt_q == (QPTR_W + 1)'(QUEUE_DEPTH);
  assign empty_o = cnt_q == '0;
  assign job_o   = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= wr_q + QPTR_W'(1);
      end
      if (pop_i) begin
        rd_q <= rd_q + QPTR_W'(1);
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + (QPTR_W + 1)'(1);
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - (QPTR_W + 1)'(1);
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o)
    else $error("push into a full queue");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !empty_o)
    else $error("pop from an empty queue");

endmodule

// ----- sv/rza_back.sv -----
// rza_back: divides the zone sums by the pixel count, one quotient bit per cycle,
// and holds the result in the output register. Depends on rza_pkg.
`timescale 1ns / 1ps

module rza_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  output logic          pop_o,
  input  rza_pkg::job_t job_i,
  input  logic          empty_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output rza_pkg::res_t out_data_o
);
  import rza_pkg::*;

  localparam logic [1:0] BK_IDLE = 2'd0;
  localparam logic [1:0] BK_DIV  = 2'd1;
  localparam logic [1:0] BK_OUT  = 2'd2;

  logic [1:0]         st_q;
  logic [QSTEP_W-1:0] step_q;
  logic [SUM_W-1:0]   rrem_q, grem_q, brem_q;
  logic [SUM_W-1:0]   dsh_q;
  logic [PIX_W-1:0]   rquo_q, gquo_q, bquo_q;
  logic [ZIDX_W-1:0]  zone_q;
  logic [LEN_W-1:0]   cnt_q;
  logic               last_q;
  logic               out_valid_q;
  res_t               out_q;

  logic rge, gge, bge;
  logic out_free;

  assign rge      = rrem_q >= dsh_q;
  assign gge      = grem_q >= dsh_q;
  assign bge      = brem_q >= dsh_q;
  assign out_free = !out_valid_q || out_ready_i;
  assign pop_o    = (st_q == BK_IDLE) && !empty_i;

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= BK_IDLE;
      step_q      <= '0;
      rrem_q      <= '0;
      grem_q      <= '0;
      brem_q      <= '0;
      dsh_q       <= '0;
      rquo_q      <= '0;
      gquo_q      <= '0;
      bquo_q      <= '0;
      zone_q      <= '0;
      cnt_q       <= '0;
      last_q      <= 1'b0;
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (st_q)
        BK_IDLE: begin
          if (!empty_i) begin
            rrem_q <= job_i.red_sum;
            grem_q <= job_i.green_sum;
            brem_q <= job_i.blue_sum;
            dsh_q  <= SUM_W'({job_i.cnt, {(PIX_W - 1){1'b0}}});
            rquo_q <= '0;
            gquo_q <= '0;
            bquo_q <= '0;
            zone_q <= job_i.zone;
            cnt_q  <= job_i.cnt;
            last_q <= job_i.last;
            step_q <= QSTEP_W'(PIX_W - 1);
            st_q   <= (job_i.cnt == '0) ? BK_OUT : BK_DIV;
          end
        end
        BK_DIV: begin
          if (rge) begin
            rrem_q <= rrem_q - dsh_q;
          end
          if (gge) begin
            grem_q <= grem_q - dsh_q;
          end
          if (bge) begin
            brem_q <= brem_q - dsh_q;
          end
          rquo_q <= {rquo_q[PIX_W-2:0], rge};
          gquo_q <= {gquo_q[PIX_W-2:0], gge};
          bquo_q <= {bquo_q[PIX_W-2:0], bge};
          dsh_q  <= dsh_q >> 1;
          step_q <= step_q - QSTEP_W'(1);
          if (step_q == '0) begin
            st_q <= BK_OUT;
          end
        end
        BK_OUT: begin
          if (out_free) begin
            out_q <= '{zone_index: zone_q, avg_red: rquo_q, avg_green: gquo_q,
                       avg_blue: bquo_q, last_zone: last_q};
            out_valid_q <= 1'b1;
            st_q        <= BK_IDLE;
          end
        end
        default: begin
          st_q <= BK_IDLE;
        end
      endcase
    end
  end

  a_quotient_fits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == BK_OUT && cnt_q != '0)
      |-> (rrem_q < SUM_W'(cnt_q) && grem_q < SUM_W'(cnt_q) && brem_q < SUM_W'(cnt_q)))
    else $error("average did not fit the quotient width");

endmodule

// ----- sv/rgb_zone_averager_top.sv -----
// rgb_zone_averager_top: per-zone RGB averages over a streamed sensor line; uses rza_pkg,
// rza_front, rza_queue and rza_back. Pixels are taken one per cycle while the zone queue has room,
// no zone size is being divided out and no empty zones are going out. Each zone result passes
// through the bit-serial averaging divider; an empty zone skips the division. With zero zone size
// the first pixel of a line holds input off while the empty zones go out. A register write blocks
// pixels while the zone size is divided out. Reset (async, low): 4096 px, 16 zones.
`timescale 1ns / 1ps

module rgb_zone_averager_top (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  rza_pkg::pix_t                  in_data_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output rza_pkg::res_t                  out_data_o,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [rza_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [rza_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import rza_pkg::*;

  logic q_push, q_full, q_pop, q_empty;
  job_t q_wr_job, q_rd_job;

  rza_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .q_push_o    (q_push),
    .q_job_o     (q_wr_job),
    .q_full_i    (q_full)
  );

  rza_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .job_i   (q_wr_job),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .job_o   (q_rd_job),
    .empty_o (q_empty)
  );

  rza_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pop_o       (q_pop),
    .job_i       (q_rd_job),
    .empty_i     (q_empty),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

// ----- tb/tb.sv -----
// tb: self-checking testbench for rgb_zone_averager_top; uses rza_pkg types and register indexes.
// Predicts per-zone RGB averages in-bench and checks every output transfer in order.
`timescale 1ns / 1ps

module tb;
  import rza_pkg::*;

  localparam int TIMEOUT_CYCLES  = 10_000_000;
  localparam int SETTLE_CYCLES   = 30;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int RANDOM_ITEMS    = 40;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = CFG_IDX_W'(7);

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  in_valid_i;
  logic                  in_ready_o;
  pix_t                  in_data_i;
  logic                  out_valid_o;
  logic                  out_ready_i;
  res_t                  out_data_o;
  logic                  cfg_valid_i;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  rgb_zone_averager_top dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  // in-bench copy of the registers and line state
  logic [LEN_W-1:0]  line_len_reg = LEN_RESET;
  logic [ZCNT_W-1:0] zone_cnt_reg = ZCNT_RESET;
  int unsigned sum_red = 0, sum_green = 0, sum_blue = 0;
  int unsigned line_pos = 0, zone_num = 0, zone_pixels = 0;

  res_t zone_avg_q[$];
  int   errors = 0;
  int   cycle_count = 0;
  bit   no_gaps = 1'b0;
  bit   hold_off_req = 1'b0;

  function automatic int unsigned eff_line_length();
    if (line_len_reg == 0) return 1;
    if (line_len_reg > LEN_MAX) return MAX_LINE_PIXELS;
    return 32'(line_len_reg);
  endfunction

  function automatic void push_zone(int unsigned z, int unsigned r, int unsigned g,
                                    int unsigned b, bit last);
    res_t e;
    e.zone_index = ZIDX_W'(z);
    e.avg_red    = PIX_W'(r);
    e.avg_green  = PIX_W'(g);
    e.avg_blue   = PIX_W'(b);
    e.last_zone  = last;
    zone_avg_q.push_back(e);
  endfunction

  function automatic void apply_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    if (idx == CFG_LINE_LENGTH) line_len_reg = data[LEN_W-1:0];
    else if (idx == CFG_ZONE_COUNT) zone_cnt_reg = data[ZCNT_W-1:0];
    if (idx == CFG_LINE_LENGTH || idx == CFG_ZONE_COUNT) begin
      sum_red = 0;
      sum_green = 0;
      sum_blue = 0;
      line_pos = 0;
      zone_num = 0;
      zone_pixels = 0;
    end
  endfunction

  // expected zone averages caused by one accepted pixel
  function automatic void average_pixel(pix_t p);
    int unsigned len, zones, zsize, last_idx;
    bit closes, last;
    len = eff_line_length();
    zones = (zone_cnt_reg == 0) ? 1 : (zone_cnt_reg > ZCNT_MAX) ? MAX_ZONES : 32'(zone_cnt_reg);
    zsize = len / zones;
    last_idx = zones - 1;
    if (line_pos == 0 && zsize == 0) begin
      for (int unsigned z = 0; z < last_idx; z++) push_zone(z, 0, 0, 0, 1'b0);
      zone_num = last_idx;
    end
    sum_red += 32'(p.red);
    sum_green += 32'(p.green);
    sum_blue += 32'(p.blue);
    zone_pixels++;
    line_pos++;
    closes = (zone_num >= last_idx) ? (line_pos >= len) : (zone_pixels >= zsize);
    if (closes) begin
      last = (zone_num >= last_idx);
      push_zone(zone_num, sum_red / zone_pixels, sum_green / zone_pixels,
                sum_blue / zone_pixels, last);
      sum_red = 0;
      sum_green = 0;
      sum_blue = 0;
      zone_pixels = 0;
      if (last) begin
        line_pos = 0;
        zone_num = 0;
      end else begin
        zone_num++;
      end
    end
  endfunction

  function automatic int pick_gap();
    int r;
    if (no_gaps) return 0;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [PIX_W-1:0] rand_channel();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return '0;
    if (r == 1) return '1;
    return PIX_W'($urandom_range(0, 255));
  endfunction

  function automatic pix_t rand_pixel();
    pix_t p;
    p.red   = rand_channel();
    p.green = rand_channel();
    p.blue  = rand_channel();
    return p;
  endfunction

  function automatic logic [CFG_DATA_W-1:0] rand_length();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return CFG_DATA_W'($urandom_range(1, 48));
    if (r < 80) return CFG_DATA_W'($urandom_range(49, 300));
    if (r < 85) return '0;
    if (r < 92) return CFG_DATA_W'(LEN_MAX);
    return CFG_DATA_W'($urandom_range(MAX_LINE_PIXELS + 1, (1 << LEN_W) - 1));
  endfunction

  // upper data bits are outside the zone count register
  function automatic logic [CFG_DATA_W-1:0] rand_zones();
    logic [CFG_DATA_W-1:0] d;
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) d = CFG_DATA_W'($urandom_range(1, 16));
    else if (r < 75) d = CFG_DATA_W'($urandom_range(17, MAX_ZONES));
    else if (r < 85) d = '0;
    else if (r < 92) d = CFG_DATA_W'($urandom_range(MAX_ZONES + 1, (1 << ZCNT_W) - 1));
    else d = CFG_DATA_W'(ZCNT_MAX);
    if ($urandom_range(0, 3) == 0) d[CFG_DATA_W-1:ZCNT_W] = (CFG_DATA_W - ZCNT_W)'($urandom() >> 3);
    return d;
  endfunction

  // returns right after the rising edge at which the pixel transfer happened
  task automatic send_pixel(input pix_t p);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= p;
    do @(posedge clk_i); while (!in_ready_o);
    average_pixel(p);
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (zone_avg_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    wait_drained();
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    apply_reg(idx, data);
  endtask

  task automatic set_line(input int len, input int zones);
    write_reg(CFG_LINE_LENGTH, CFG_DATA_W'(len));
    write_reg(CFG_ZONE_COUNT, CFG_DATA_W'(zones));
  endtask

  task automatic test_zone_split();
    repeat (3) send_pixel(rand_pixel());
    set_line(4, 2);
    send_pixel('{red: 8'h00, green: 8'h00, blue: 8'h00});
    send_pixel('{red: 8'hff, green: 8'hff, blue: 8'hff});
    send_pixel('{red: 8'hff, green: 8'h00, blue: 8'h80});
    send_pixel('{red: 8'h01, green: 8'hfe, blue: 8'h7f});
    // last zone takes the remainder
    set_line(5, 2);
    repeat (5) send_pixel(rand_pixel());
  endtask

  task automatic test_empty_zones();
    set_line(1, MAX_ZONES);
    send_pixel(rand_pixel());
    set_line(3, 5);
    repeat (3) send_pixel(rand_pixel());
  endtask

  task automatic test_register_clamps();
    set_line(0, 0);
    repeat (2) send_pixel(rand_pixel());
    set_line(100, (1 << ZCNT_W) - 1);
    repeat (2) send_pixel(rand_pixel());
    write_reg(CFG_LINE_LENGTH, CFG_DATA_W'(2));
    write_reg(CFG_ZONE_COUNT, 13'h1f81);
    repeat (2) send_pixel(rand_pixel());
    set_line((1 << LEN_W) - 1, MAX_ZONES);
    send_pixel(rand_pixel());
  endtask

  task automatic test_line_restart();
    set_line(4, 1);
    repeat (2) send_pixel(rand_pixel());
    write_reg(CFG_UNUSED, CFG_DATA_W'($urandom()));
    repeat (3) send_pixel(rand_pixel());
    write_reg(CFG_ZONE_COUNT, CFG_DATA_W'(1));
    repeat (4) send_pixel(rand_pixel());
  endtask

  task automatic test_max_line();
    set_line(MAX_LINE_PIXELS, MAX_ZONES);
    repeat (MAX_LINE_PIXELS / MAX_ZONES) send_pixel(rand_pixel());
  endtask

  task automatic test_backpressure();
    set_line(2, 2);
    hold_off_req = 1'b1;
    no_gaps = 1'b1;
    repeat (40) send_pixel(rand_pixel());
    no_gaps = 1'b0;
    wait_drained();
    repeat (10) send_pixel(rand_pixel());
  endtask

  task automatic test_random_lines();
    int unsigned sent, n, len;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      if ($urandom_range(0, 1)) begin
        write_reg(CFG_LINE_LENGTH, rand_length());
        write_reg(CFG_ZONE_COUNT, rand_zones());
      end else begin
        write_reg(CFG_ZONE_COUNT, rand_zones());
        write_reg(CFG_LINE_LENGTH, rand_length());
      end
      if ($urandom_range(0, 4) == 0) begin
        write_reg(CFG_IDX_W'($urandom_range(int'(CFG_ZONE_COUNT) + 1, (1 << CFG_IDX_W) - 1)),
                  CFG_DATA_W'($urandom()));
      end
      len = eff_line_length();
      if (len <= 48) n = len * $urandom_range(1, 2) + $urandom_range(0, 3);
      else n = $urandom_range(1, 40);
      no_gaps = ($urandom_range(0, 5) == 0);
      repeat (n) send_pixel(rand_pixel());
      no_gaps = 1'b0;
      sent += n;
    end
  endtask

  // receiver: random ready bursts and stalls, plus one long hold-off on request
  initial begin : rx_ready
    int hold_left, burst_left, stall_left;
    hold_left = 0;
    burst_left = 0;
    stall_left = 0;
    out_ready_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        hold_left = HOLD_OFF_CYCLES;
      end
      if (hold_left > 0) begin
        out_ready_i <= 1'b0;
        hold_left--;
      end else if (no_gaps) begin
        out_ready_i <= 1'b1;
      end else begin
        if (burst_left == 0 && stall_left == 0) begin
          burst_left = $urandom_range(1, 8);
          stall_left = pick_gap();
        end
        if (burst_left > 0) begin
          out_ready_i <= 1'b1;
          burst_left--;
        end else begin
          out_ready_i <= 1'b0;
          stall_left--;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    res_t e;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (zone_avg_q.size() == 0) begin
        $error("unexpected result transfer: zone_index %0d", out_data_o.zone_index);
        errors++;
      end else begin
        e = zone_avg_q.pop_front();
        if (out_data_o.zone_index !== e.zone_index) begin
          $error("zone_index: expected %0d, got %0d", e.zone_index, out_data_o.zone_index);
          errors++;
        end
        if (out_data_o.avg_red !== e.avg_red) begin
          $error("avg_red: expected %0d, got %0d", e.avg_red, out_data_o.avg_red);
          errors++;
        end
        if (out_data_o.avg_green !== e.avg_green) begin
          $error("avg_green: expected %0d, got %0d", e.avg_green, out_data_o.avg_green);
          errors++;
        end
        if (out_data_o.avg_blue !== e.avg_blue) begin
          $error("avg_blue: expected %0d, got %0d", e.avg_blue, out_data_o.avg_blue);
          errors++;
        end
        if (out_data_o.last_zone !== e.last_zone) begin
          $error("last_zone: expected %0d, got %0d", e.last_zone, out_data_o.last_zone);
          errors++;
        end
      end
    end
  end

  initial begin
    while (cycle_count < TIMEOUT_CYCLES) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("Some tests failed");
    $finish;
  end

  initial begin
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    in_data_i   = '0;
    cfg_valid_i = 1'b0;
    cfg_index_i = '0;
    cfg_data_i  = '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_zone_split();
    test_empty_zones();
    test_register_clamps();
    test_line_restart();
    test_max_line();
    test_backpressure();
    test_random_lines();
    wait_drained();
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
sv/rza_pkg.sv
sv/rza_front.sv
sv/rza_queue.sv
sv/rza_back.sv
sv/rgb_zone_averager_top.sv
tb/tb.sv
